/* src/request_queue_scheduler_unit_defines.svh */
// Assertion macros shared by the request queue scheduler RTL.
`ifndef REQUEST_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define REQUEST_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define RQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rqs_pkg.sv */
// Shared types, constants and helper functions of the request queue scheduler.
package rqs_pkg;

  localparam int unsigned RQS_DEPTH  = 64;
  localparam int unsigned CONN_W     = 16;
  localparam int unsigned SIZE_W     = 31;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIFO   = 2'd0,
    MODE_SFF    = 2'd1,
    MODE_RANDOM = 2'd2
  } mode_e;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_MODE = 1'b0,
    CFG_CAPACITY   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CONN_W-1:0]   conn_id;
    logic [SIZE_W-1:0]   file_size;
    logic [HANDLE_W-1:0] name_handle;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_e           status;
    entry_t            entry;
    logic [FILL_W-1:0] fill;
  } result_t;

  // Fibonacci LFSR, taps 16, 14, 13, 11, shifting right.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

/* src/rqs_if.sv */
// Handshake channel interfaces: request, response and configuration write.
interface rqs_req_if import rqs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [CONN_W-1:0]   conn_id;
  logic [SIZE_W-1:0]   file_size;
  logic [HANDLE_W-1:0] name_handle;

  modport source (output valid, command, conn_id, file_size, name_handle, input ready);
  modport sink   (input valid, command, conn_id, file_size, name_handle, output ready);
endinterface

interface rqs_rsp_if import rqs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CONN_W-1:0]   out_conn_id;
  logic [SIZE_W-1:0]   out_file_size;
  logic [HANDLE_W-1:0] out_name_handle;
  logic [FILL_W-1:0]   fill_level;

  modport source (output valid, status, out_conn_id, out_file_size, out_name_handle,
                  fill_level, input ready);
  modport sink   (input valid, status, out_conn_id, out_file_size, out_name_handle,
                  fill_level, output ready);
endinterface

interface rqs_cfg_if import rqs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/rqs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/rqs_modulo.sv */
// Restoring remainder unit: LFSR value modulo the entry count, one bit a cycle.
module rqs_modulo import rqs_pkg::*; #(
  parameter int unsigned DIV_W = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LFSR_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  rem_o
);

  localparam int unsigned STEP_W = $clog2(LFSR_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [LFSR_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial = {rem_q, dvd_q[LFSR_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // subtract when the partial remainder reaches the divisor
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[DIV_W-1:0];
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
      dvd_d  = {dvd_q[LFSR_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(LFSR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* src/request_queue_scheduler_unit.sv */
// Request queue scheduler: ordered request store with FIFO, SFF and random service.
// Enqueue or refusal: the result waits in S_DONE for the response register. Dequeue:
// an SFF scan or random remainder first, a read of the pick, then the later entries
// shift down (not when the last entry goes); the one-read-port RAM serialises these.
// One request at a time; the next is taken as soon as the result moves to the output.
// Reset clears the count and loads the LFSR with 0xACE1; RAM contents stay undefined.
`include "request_queue_scheduler_unit_defines.svh"

module request_queue_scheduler_unit import rqs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = RQS_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rqs_cfg_if.sink    cfg_i,
  rqs_req_if.sink    req_i,
  rqs_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [CW-1:0]     scan_ptr_q, scan_ptr_d;
  logic              scan_vld_q, scan_vld_d;
  logic [AW-1:0]     scan_at_q, scan_at_d;
  logic [SIZE_W-1:0] min_size_q, min_size_d;
  logic [AW-1:0]     min_idx_q, min_idx_d;
  logic [AW-1:0]     pick_q, pick_d;
  logic [CW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic              shift_vld_q, shift_vld_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  entry_t             wr_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_rem;

  logic req_accept;
  logic full;
  logic take_min;

  assign rd_entry   = entry_t'(ram_rdata);
  assign req_accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Refuse an enqueue at min(capacity, depth) entries.
  assign full = (LW'(count_q) >= LW'(cap_q)) || (count_q == CW'(QUEUE_DEPTH));

  // Earliest entry wins a tie on size: replace only on strictly smaller.
  assign take_min = (scan_at_q == '0) || (rd_entry.file_size < min_size_q);

  rqs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rqs_modulo #(
    .DIV_W (CW)
  ) u_modulo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lfsr_d),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lfsr_d      = lfsr_q;
    mode_d      = mode_q;
    cap_d       = cap_q;
    scan_ptr_d  = scan_ptr_q;
    scan_vld_d  = scan_vld_q;
    scan_at_d   = scan_at_q;
    min_size_d  = min_size_q;
    min_idx_d   = min_idx_q;
    pick_d      = pick_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    shift_vld_d = shift_vld_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_raddr   = '0;
    wr_entry    = '{conn_id: req_i.conn_id, file_size: req_i.file_size,
                    name_handle: req_i.name_handle};
    mod_start   = 1'b0;

    // Take configuration writes at any time; mode and capacity are read only
    // when a request is accepted.
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SCHED_MODE: mode_d = cfg_i.data[MODE_W-1:0];
        CFG_CAPACITY:   cap_d  = cfg_i.data[CAP_W-1:0];
        default:        ;
      endcase
    end

    // Drop the response once the consumer takes it.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          res_d.entry = '0;
          res_d.fill  = FILL_W'(count_q);
          state_d     = S_DONE;
          if (req_i.command == CMD_ENQ) begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              // append at the tail
              ram_we       = 1'b1;
              count_d      = count_q + CW'(1);
              res_d.status = ST_ENQ;
              res_d.fill   = FILL_W'(count_d);
            end
          end else if (count_q == '0) begin
            res_d.status = ST_EMPTY;
          end else begin
            case (mode_q)
              MODE_SFF: begin
                scan_ptr_d = '0;
                scan_vld_d = 1'b0;
                state_d    = S_SCAN;
              end
              MODE_RANDOM: begin
                // advance the LFSR before use, then reduce modulo the count
                lfsr_d    = lfsr_next(lfsr_q);
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
              default: begin
                pick_d  = '0;
                state_d = S_READ;
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        // issue one read a cycle, compare the entry that returns
        if (scan_ptr_q < count_q) begin
          ram_raddr  = scan_ptr_q[AW-1:0];
          scan_ptr_d = scan_ptr_q + CW'(1);
          scan_at_d  = scan_ptr_q[AW-1:0];
          scan_vld_d = 1'b1;
        end else begin
          scan_vld_d = 1'b0;
        end
        if (scan_vld_q) begin
          if (take_min) begin
            min_size_d = rd_entry.file_size;
            min_idx_d  = scan_at_q;
          end
          if (CW'(scan_at_q) + CW'(1) == count_q) begin
            pick_d  = take_min ? scan_at_q : min_idx_q;
            state_d = S_READ;
          end
        end
      end

      S_MOD: begin
        if (mod_done) begin
          pick_d  = mod_rem[AW-1:0];
          state_d = S_READ;
        end
      end

      S_READ: begin
        ram_raddr = pick_q;
        state_d   = S_FETCH;
      end

      S_FETCH: begin
        res_d.status = ST_DEQ;
        res_d.entry  = rd_entry;
        res_d.fill   = FILL_W'(count_q - CW'(1));
        rd_ptr_d     = CW'(pick_q) + CW'(1);
        wr_ptr_d     = pick_q;
        shift_vld_d  = 1'b0;
        if (rd_ptr_d < count_q) begin
          state_d = S_SHIFT;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        // close the gap: read two ahead of the write, one entry a cycle
        if (rd_ptr_q < count_q) begin
          ram_raddr   = rd_ptr_q[AW-1:0];
          rd_ptr_d    = rd_ptr_q + CW'(1);
          shift_vld_d = 1'b1;
        end else begin
          shift_vld_d = 1'b0;
        end
        if (shift_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr_q;
          wr_entry  = rd_entry;
          wr_ptr_d  = wr_ptr_q + AW'(1);
          if (CW'(wr_ptr_q) + CW'(2) == count_q) begin
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        // hold the result until the response register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      mode_q      <= MODE_FIFO;
      cap_q       <= CAP_RESET;
      scan_vld_q  <= 1'b0;
      shift_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      lfsr_q      <= lfsr_d;
      mode_q      <= mode_d;
      cap_q       <= cap_d;
      scan_vld_q  <= scan_vld_d;
      shift_vld_q <= shift_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    scan_at_q  <= scan_at_d;
    min_size_q <= min_size_d;
    min_idx_q  <= min_idx_d;
    pick_q     <= pick_d;
    rd_ptr_q   <= rd_ptr_d;
    wr_ptr_q   <= wr_ptr_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.out_conn_id     = out_q.entry.conn_id;
  assign rsp_o.out_file_size   = out_q.entry.file_size;
  assign rsp_o.out_name_handle = out_q.entry.name_handle;
  assign rsp_o.fill_level      = out_q.fill;

  `RQS_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "entry count above depth")
  `RQS_ASSERT_NEXT(a_enq_count, req_accept && req_i.command == CMD_ENQ && !full, count_q == $past(count_q) + CW'(1), "accepted enqueue did not grow the count")
  `RQS_ASSERT(a_mod_range, !mod_done || (mod_rem < count_q), "random pick outside the queue")
  `RQS_ASSERT(a_shift_hazard, !(state_q == S_SHIFT && ram_we && rd_ptr_q < count_q) || (ram_raddr != ram_waddr), "shift reads the entry it writes")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the request queue scheduler: directed cases, then random traffic.
module testbench import rqs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam time CLK_PERIOD = 8ns;
  // Mode code that has no enum member. The block must treat it as first in first out.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PHASES = 13;
  localparam int unsigned PHASE_REQUESTS = 100;
  // Quiet time after the drain in which any stray response is caught before the final verdict.
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned REPORT_LIMIT = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  rqs_cfg_if cfg_bus ();
  rqs_req_if req_bus ();
  rqs_rsp_if rsp_bus ();

  request_queue_scheduler_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the scheduler: queued requests in arrival order, the two
  // registers and the LFSR that drives random picks.
  // ---------------------------------------------------------------------------
  entry_t            queued_requests[$];
  logic [MODE_W-1:0] sched_mode_q = MODE_FIFO;
  logic [CAP_W-1:0]  capacity_q   = CAP_RESET;
  logic [LFSR_W-1:0] lfsr_q       = LFSR_SEED;

  // Responses still owed by the block, oldest first.
  result_t     awaited_results[$];
  int unsigned mismatch_count = 0;

  // Sender burst state.
  int unsigned burst_left = 0;

  // Receiver stall state.
  int unsigned ready_pattern = 0;
  int unsigned pattern_age = 0;
  int unsigned stall_left = 0;

  // Apply one request to the shadow queue and return the response it must cause.
  function automatic result_t serve_request(input cmd_e cmd, input entry_t payload);
    result_t     outcome;
    int unsigned limit;
    int unsigned pick;
    outcome = '0;
    // A capacity above the store depth is clipped to the depth.
    limit = (capacity_q < RQS_DEPTH) ? capacity_q : RQS_DEPTH;
    if (cmd == CMD_ENQ) begin
      if (queued_requests.size() >= limit) begin
        outcome.status = ST_FULL;
      end else begin
        queued_requests.push_back(payload);
        outcome.status = ST_ENQ;
      end
    end else if (queued_requests.size() == 0) begin
      outcome.status = ST_EMPTY;
    end else begin
      pick = 0;
      if (sched_mode_q == MODE_SFF) begin
        // Strict less-than keeps the earliest entry on equal sizes.
        for (int unsigned i = 1; i < queued_requests.size(); i++) begin
          if (queued_requests[i].file_size < queued_requests[pick].file_size) pick = i;
        end
      end else if (sched_mode_q == MODE_RANDOM) begin
        // Advance the LFSR before use: feedback from bits 0, 2, 3 and 5 enters at the top.
        lfsr_q = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};
        pick = lfsr_q % queued_requests.size();
      end
      // Any other mode, the unused code included, serves the oldest entry.
      outcome.entry = queued_requests[pick];
      queued_requests.delete(pick);
      outcome.status = ST_DEQ;
    end
    outcome.fill = FILL_W'(queued_requests.size());
    return outcome;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Work in bursts of random length. Between bursts, hold valid
  // low for a random gap. Some bursts follow with no gap at all.
  // ---------------------------------------------------------------------------
  task automatic send_request(input cmd_e cmd, input entry_t payload);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        req_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_bus.valid       <= 1'b1;
    req_bus.command     <= cmd;
    req_bus.conn_id     <= payload.conn_id;
    req_bus.file_size   <= payload.file_size;
    req_bus.name_handle <= payload.name_handle;
    // Hold the request until the block takes it, then record what it owes.
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    awaited_results.push_back(serve_request(cmd, payload));
  endtask

  // Drop valid once the last request of a sequence has been taken.
  task automatic request_idle();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
  endtask

  // Wait until every owed response has come back.
  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Write one register. Every request yields exactly one response, so the
  // block is idle once nothing is owed.
  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    request_idle();
    wait_drained();
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    if (idx == CFG_SCHED_MODE) sched_mode_q = value[MODE_W-1:0];
    else                       capacity_q   = value[CAP_W-1:0];
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Response receiver. Switch now and then between always ready, short
  // frequent stalls and long rare stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (pattern_age == 0) begin
      pattern_age   = $urandom_range(100, 400);
      ready_pattern = $urandom_range(0, 2);
    end
    pattern_age--;
    if (stall_left != 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_bus.ready <= 1'b1;
      case (ready_pattern)
        1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
        2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 20);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Response checker. Compare each accepted response with the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    result_t seen;
    result_t want;
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      seen.status            = status_e'(rsp_bus.status);
      seen.entry.conn_id     = rsp_bus.out_conn_id;
      seen.entry.file_size   = rsp_bus.out_file_size;
      seen.entry.name_handle = rsp_bus.out_name_handle;
      seen.fill              = rsp_bus.fill_level;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: response with none owed: status %0d conn %h size %h handle %h fill %0d",
                   $realtime, seen.status, seen.entry.conn_id, seen.entry.file_size,
                   seen.entry.name_handle, seen.fill);
      end else begin
        want = awaited_results.pop_front();
        if (seen.status !== want.status || seen.entry.conn_id !== want.entry.conn_id ||
            seen.entry.file_size !== want.entry.file_size ||
            seen.entry.name_handle !== want.entry.name_handle || seen.fill !== want.fill) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: expected status %0d conn %h size %h handle %h fill %0d",
                     $realtime, want.status, want.entry.conn_id, want.entry.file_size,
                     want.entry.name_handle, want.fill);
            $display("%0t: actual   status %0d conn %h size %h handle %h fill %0d",
                     $realtime, seen.status, seen.entry.conn_id, seen.entry.file_size,
                     seen.entry.name_handle, seen.fill);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset values: first in first out with room for one entry. Also check that
  // a dequeue ignores its data fields and that all-zero field values pass.
  task automatic test_reset_state();
    send_request(CMD_DEQ, '{16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF});
    send_request(CMD_ENQ, '{16'h0000, 31'h0000_0000, 32'h0000_0000});
    send_request(CMD_ENQ, '{16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF});
    send_request(CMD_DEQ, '{16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF});
  endtask

  // Smallest size first, with a tie that the earlier entry must win. The
  // capacity goes above the store depth.
  task automatic test_smallest_first();
    write_register(CFG_CAPACITY, 7'd127);
    write_register(CFG_SCHED_MODE, CFG_DATA_W'(MODE_SFF));
    send_request(CMD_ENQ, '{16'h0001, 31'd5, 32'hA5A5_0001});
    send_request(CMD_ENQ, '{16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF});
    send_request(CMD_ENQ, '{16'h0003, 31'd5, 32'h5A5A_0003});
    send_request(CMD_ENQ, '{16'h0000, 31'd0, 32'h0000_0000});
    repeat (4) send_request(CMD_DEQ, '{16'h1234, 31'd1, 32'h0});
  endtask

  // Unused mode code, a small capacity, then capacity zero while entries are
  // held: enqueues are refused and dequeues still work.
  task automatic test_capacity_limits();
    write_register(CFG_SCHED_MODE, {5'h1F, MODE_UNUSED});
    write_register(CFG_CAPACITY, 7'd2);
    send_request(CMD_ENQ, '{16'h00A0, 31'd900, 32'h0000_00A0});
    send_request(CMD_ENQ, '{16'h00B0, 31'd10, 32'h0000_00B0});
    send_request(CMD_ENQ, '{16'h00C0, 31'd1, 32'h0000_00C0});
    write_register(CFG_CAPACITY, 7'd0);
    send_request(CMD_ENQ, '{16'h00D0, 31'd0, 32'h0000_00D0});
    send_request(CMD_DEQ, '{16'h0, 31'd0, 32'h0});
  endtask

  // Random pick from a single entry, then a random-mode dequeue on empty,
  // which must leave the LFSR alone.
  task automatic test_random_pick();
    write_register(CFG_CAPACITY, 7'd64);
    write_register(CFG_SCHED_MODE, {5'h1F, MODE_RANDOM});
    send_request(CMD_DEQ, '{16'h0, 31'd0, 32'h0});
    send_request(CMD_DEQ, '{16'h0, 31'd0, 32'h0});
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic. Each phase sets a mode and a capacity, then mixes filling,
  // draining and balanced stretches at random so that the fill level sweeps
  // from empty to the limit. Sizes often fall in a narrow range to force ties.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic();
    logic [MODE_W-1:0] mode_plan[4];
    logic [CAP_W-1:0]  cap_plan[9];
    logic [CAP_W-1:0]  cap;
    int unsigned       chunk_left;
    int unsigned       enq_pct;
    cmd_e              cmd;
    entry_t            payload;
    mode_plan  = '{MODE_FIFO, MODE_SFF, MODE_RANDOM, MODE_UNUSED};
    cap_plan   = '{7'd64, 7'd127, 7'd1, 7'd64, 7'd0, 7'd2, 7'd63, 7'd65, 7'd64};
    chunk_left = 0;
    enq_pct    = 50;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      cap = (phase < 9) ? cap_plan[phase] : CAP_W'($urandom_range(1, 64));
      // Put noise in the unused upper bits of the mode write.
      write_register(CFG_SCHED_MODE, {5'($urandom), mode_plan[phase % 4]});
      write_register(CFG_CAPACITY, cap);
      for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
        if (chunk_left == 0) begin
          chunk_left = $urandom_range(10, 70);
          case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 15;
            default: enq_pct = 50;
          endcase
        end
        chunk_left--;
        cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        payload.conn_id     = CONN_W'($urandom);
        payload.name_handle = HANDLE_W'($urandom);
        case ($urandom_range(0, 3))
          0:       payload.file_size = SIZE_W'($urandom_range(0, 7));
          1:       payload.file_size = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
          default: payload.file_size = SIZE_W'($urandom);
        endcase
        send_request(cmd, payload);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.command     = CMD_ENQ;
    req_bus.conn_id     = '0;
    req_bus.file_size   = '0;
    req_bus.name_handle = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_SCHED_MODE;
    cfg_bus.data        = '0;
    rsp_bus.ready       = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_smallest_first();
    test_capacity_limits();
    test_random_pick();
    test_random_traffic();

    // Drain, then watch for stray responses before the verdict.
    request_idle();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
